### hdl/vertex_transform_unit_macros.svh
// Assertion macros used by the checker of the vertex transform unit.
`ifndef VERTEX_TRANSFORM_UNIT_MACROS_SVH
`define VERTEX_TRANSFORM_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VTU_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vertex transform unit check failed");

// Consequent must hold a fixed number of cycles after the antecedent.
`define VTU_ASSERT_AFTER(name, clk, rst_n, ante, n, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("vertex transform unit timing check failed");

`endif

### hdl/vtu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vtu_pkg;

    // Field widths
    localparam int COORD_WIDTH = 32;
    localparam int ANGLE_WIDTH = 16;
    localparam int MODE_WIDTH  = 3;
    localparam int TRIG_WIDTH  = 32;
    localparam int ACC_WIDTH   = 32;
    localparam int OPA_WIDTH   = (TRIG_WIDTH > COORD_WIDTH) ? TRIG_WIDTH : COORD_WIDTH;

    // Operation codes
    localparam logic [MODE_WIDTH-1:0] MODE_TRANSLATE = 3'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_ROTATE_X  = 3'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_ROTATE_Y  = 3'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_ROTATE_Z  = 3'd3;
    localparam logic [MODE_WIDTH-1:0] MODE_SCALE     = 3'd4;

    // Quadrant codes of the angle fold
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Angle fold: one eighth of a turn centers each quadrant
    localparam logic [ANGLE_WIDTH-1:0] ANGLE_OCTANT = 16'h2000;

    // CORDIC setup
    localparam int CORDIC_STAGES_DEFAULT = 16;
    localparam int MAX_STAGES            = 24;
    localparam logic signed [TRIG_WIDTH-1:0] CORDIC_GAIN = 32'sd652032874;

    // Arctangent of 2^-i in units of 2^-32 turn
    localparam logic [ACC_WIDTH-1:0] ATAN_TURNS [MAX_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Fraction bits dropped after each product kind
    localparam int ROT_FRAC   = 30;
    localparam int SCALE_FRAC = 16;

    // Register stages of an axis lane
    localparam int LANE_LATENCY = 3;

    typedef struct packed {
        logic [MODE_WIDTH-1:0]         mode;
        logic signed [COORD_WIDTH-1:0] vertex_x;
        logic signed [COORD_WIDTH-1:0] vertex_y;
        logic signed [COORD_WIDTH-1:0] vertex_z;
        logic signed [COORD_WIDTH-1:0] operand_x;
        logic signed [COORD_WIDTH-1:0] operand_y;
        logic signed [COORD_WIDTH-1:0] operand_z;
        logic [ANGLE_WIDTH-1:0]        turn_angle;
    } request_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] result_x;
        logic signed [COORD_WIDTH-1:0] result_y;
        logic signed [COORD_WIDTH-1:0] result_z;
        logic                          saturated;
    } result_t;

    typedef struct packed {
        logic signed [TRIG_WIDTH-1:0] x;
        logic signed [TRIG_WIDTH-1:0] y;
        logic signed [ACC_WIDTH-1:0]  z;
    } cordic_t;

    typedef struct packed {
        logic [1:0] quad;
        request_t   req;
        cordic_t    rot;
    } stage_t;

    typedef enum logic [1:0] {
        LANE_PASS,
        LANE_ADD,
        LANE_ROTATE,
        LANE_SCALE
    } lane_kind_t;

    typedef struct packed {
        lane_kind_t                    kind;
        logic signed [OPA_WIDTH-1:0]   a1;
        logic signed [COORD_WIDTH-1:0] b1;
        logic signed [OPA_WIDTH-1:0]   a2;
        logic signed [COORD_WIDTH-1:0] b2;
    } lane_op_t;

endpackage

`default_nettype wire

### hdl/vertex_transform_unit.sv
// Vertex transform unit: translates, rotates about X, Y or Z, or scales one
// Q16.16 vertex per clock. A request is taken at every clock edge with start
// high; busy stays low, so a new vertex may follow in every cycle. Each
// result appears for one cycle with done high, in request order; the
// receiver must take it then. A request passes through the chain of CORDIC
// cells (one register per iteration) and then the three register stages of
// each axis lane (multiply, combine, round and clip). The block holds no
// state between vertices and needs no setup after reset.
`timescale 1ns / 1ps
`default_nettype none

module vertex_transform_unit #(
    parameter int CORDIC_STAGES = vtu_pkg::CORDIC_STAGES_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire vtu_pkg::request_t request,
    output logic                   done,
    output vtu_pkg::result_t       result
);

    localparam int LL = vtu_pkg::LANE_LATENCY;

    logic [vtu_pkg::ANGLE_WIDTH-1:0]       angle_bias;
    logic [1:0]                            in_quad;
    logic [vtu_pkg::ANGLE_WIDTH-1:0]       angle_rem;
    logic [CORDIC_STAGES:0]                chain_valid;
    vtu_pkg::stage_t                       chain_data [0:CORDIC_STAGES];
    vtu_pkg::stage_t                       chain_out;
    logic signed [vtu_pkg::TRIG_WIDTH-1:0] trig_c;
    logic signed [vtu_pkg::TRIG_WIDTH-1:0] trig_s;
    logic signed [vtu_pkg::TRIG_WIDTH-1:0] trig_neg_s;
    vtu_pkg::lane_op_t                     op_x;
    vtu_pkg::lane_op_t                     op_y;
    vtu_pkg::lane_op_t                     op_z;
    logic signed [vtu_pkg::COORD_WIDTH-1:0] value_x;
    logic signed [vtu_pkg::COORD_WIDTH-1:0] value_y;
    logic signed [vtu_pkg::COORD_WIDTH-1:0] value_z;
    logic                                  clip_x;
    logic                                  clip_y;
    logic                                  clip_z;
    logic [LL-1:0]                         lane_valid_reg;
    logic [LL-1:0]                         lane_valid_next;

    // Never refuse a request
    assign busy = 1'b0;

    // Fold the angle into the quadrant nearest to it
    assign angle_bias = request.turn_angle + vtu_pkg::ANGLE_OCTANT;
    assign in_quad    = angle_bias[vtu_pkg::ANGLE_WIDTH-1 -: 2];
    assign angle_rem  = request.turn_angle - {in_quad, {(vtu_pkg::ANGLE_WIDTH-2){1'b0}}};

    // Load the first cell
    assign chain_valid[0]      = start && !busy;
    assign chain_data[0].quad  = in_quad;
    assign chain_data[0].req   = request;
    assign chain_data[0].rot.x = vtu_pkg::CORDIC_GAIN;
    assign chain_data[0].rot.y = '0;
    assign chain_data[0].rot.z = {angle_rem, {(vtu_pkg::ACC_WIDTH-vtu_pkg::ANGLE_WIDTH){1'b0}}};

    // Chain of CORDIC cells, one iteration each
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        vtu_cordic_cell #(
            .STAGE_INDEX (i),
            .ATAN_STEP   (vtu_pkg::ATAN_TURNS[i])
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    assign chain_out = chain_data[CORDIC_STAGES];

    // Unfold cosine and sine into the request's quadrant
    always_comb
    begin
        unique case (chain_out.quad)
            vtu_pkg::QUAD_0:
            begin
                trig_c = chain_out.rot.x;
                trig_s = chain_out.rot.y;
            end
            vtu_pkg::QUAD_1:
            begin
                trig_c = -chain_out.rot.y;
                trig_s = chain_out.rot.x;
            end
            vtu_pkg::QUAD_2:
            begin
                trig_c = -chain_out.rot.x;
                trig_s = -chain_out.rot.y;
            end
            default:
            begin
                trig_c = chain_out.rot.y;
                trig_s = -chain_out.rot.x;
            end
        endcase
    end

    assign trig_neg_s = -trig_s;

    // Select lane operands for the requested operation
    always_comb
    begin
        op_x = '{kind: vtu_pkg::LANE_PASS, a1: '0, b1: chain_out.req.vertex_x, a2: '0, b2: '0};
        op_y = '{kind: vtu_pkg::LANE_PASS, a1: '0, b1: chain_out.req.vertex_y, a2: '0, b2: '0};
        op_z = '{kind: vtu_pkg::LANE_PASS, a1: '0, b1: chain_out.req.vertex_z, a2: '0, b2: '0};
        unique case (chain_out.req.mode)
            vtu_pkg::MODE_TRANSLATE:
            begin
                op_x.kind = vtu_pkg::LANE_ADD;
                op_x.b2   = chain_out.req.operand_x;
                op_y.kind = vtu_pkg::LANE_ADD;
                op_y.b2   = chain_out.req.operand_y;
                op_z.kind = vtu_pkg::LANE_ADD;
                op_z.b2   = chain_out.req.operand_z;
            end
            vtu_pkg::MODE_ROTATE_X:
            begin
                op_y = '{kind: vtu_pkg::LANE_ROTATE,
                         a1: vtu_pkg::OPA_WIDTH'(trig_c),     b1: chain_out.req.vertex_y,
                         a2: vtu_pkg::OPA_WIDTH'(trig_neg_s), b2: chain_out.req.vertex_z};
                op_z = '{kind: vtu_pkg::LANE_ROTATE,
                         a1: vtu_pkg::OPA_WIDTH'(trig_s),     b1: chain_out.req.vertex_y,
                         a2: vtu_pkg::OPA_WIDTH'(trig_c),     b2: chain_out.req.vertex_z};
            end
            vtu_pkg::MODE_ROTATE_Y:
            begin
                op_x = '{kind: vtu_pkg::LANE_ROTATE,
                         a1: vtu_pkg::OPA_WIDTH'(trig_c),     b1: chain_out.req.vertex_x,
                         a2: vtu_pkg::OPA_WIDTH'(trig_s),     b2: chain_out.req.vertex_z};
                op_z = '{kind: vtu_pkg::LANE_ROTATE,
                         a1: vtu_pkg::OPA_WIDTH'(trig_c),     b1: chain_out.req.vertex_z,
                         a2: vtu_pkg::OPA_WIDTH'(trig_neg_s), b2: chain_out.req.vertex_x};
            end
            vtu_pkg::MODE_ROTATE_Z:
            begin
                op_x = '{kind: vtu_pkg::LANE_ROTATE,
                         a1: vtu_pkg::OPA_WIDTH'(trig_c),     b1: chain_out.req.vertex_x,
                         a2: vtu_pkg::OPA_WIDTH'(trig_neg_s), b2: chain_out.req.vertex_y};
                op_y = '{kind: vtu_pkg::LANE_ROTATE,
                         a1: vtu_pkg::OPA_WIDTH'(trig_s),     b1: chain_out.req.vertex_x,
                         a2: vtu_pkg::OPA_WIDTH'(trig_c),     b2: chain_out.req.vertex_y};
            end
            vtu_pkg::MODE_SCALE:
            begin
                op_x.kind = vtu_pkg::LANE_SCALE;
                op_x.a1   = vtu_pkg::OPA_WIDTH'(chain_out.req.operand_x);
                op_y.kind = vtu_pkg::LANE_SCALE;
                op_y.a1   = vtu_pkg::OPA_WIDTH'(chain_out.req.operand_y);
                op_z.kind = vtu_pkg::LANE_SCALE;
                op_z.a1   = vtu_pkg::OPA_WIDTH'(chain_out.req.operand_z);
            end
            default:
            begin
                // Unused operation codes pass the vertex through
                op_x.kind = vtu_pkg::LANE_PASS;
            end
        endcase
    end

    // One lane per axis
    vtu_axis_lane u_lane_x (
        .clk     (clk),
        .lane_op (op_x),
        .value   (value_x),
        .clipped (clip_x)
    );

    vtu_axis_lane u_lane_y (
        .clk     (clk),
        .lane_op (op_y),
        .value   (value_y),
        .clipped (clip_y)
    );

    vtu_axis_lane u_lane_z (
        .clk     (clk),
        .lane_op (op_z),
        .value   (value_z),
        .clipped (clip_z)
    );

    // Track requests through the lanes
    assign lane_valid_next = {lane_valid_reg[LL-2:0], chain_valid[CORDIC_STAGES]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lane_valid_reg <= '0;
        else
            lane_valid_reg <= lane_valid_next;
    end

    // Drive the result
    assign done = lane_valid_reg[LL-1];

    always_comb
    begin
        result.result_x  = value_x;
        result.result_y  = value_y;
        result.result_z  = value_z;
        result.saturated = clip_x || clip_y || clip_z;
    end

endmodule

`default_nettype wire

### hdl/vtu_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module vtu_cordic_cell #(
    parameter int STAGE_INDEX = 0,
    parameter logic signed [vtu_pkg::ACC_WIDTH-1:0] ATAN_STEP = vtu_pkg::ATAN_TURNS[0]
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire vtu_pkg::stage_t in_data,
    output logic                 out_valid,
    output vtu_pkg::stage_t      out_data
);

    logic                                  valid_reg;
    logic                                  valid_next;
    vtu_pkg::stage_t                       data_reg;
    vtu_pkg::stage_t                       data_next;
    logic signed [vtu_pkg::TRIG_WIDTH-1:0] x_shift;
    logic signed [vtu_pkg::TRIG_WIDTH-1:0] y_shift;

    // Floor shifts of both coordinates
    assign x_shift = in_data.rot.x >>> STAGE_INDEX;
    assign y_shift = in_data.rot.y >>> STAGE_INDEX;

    // Rotate one micro-step toward zero residual angle
    always_comb
    begin
        data_next = in_data;
        if (!in_data.rot.z[vtu_pkg::ACC_WIDTH-1])
        begin
            data_next.rot.x = in_data.rot.x - y_shift;
            data_next.rot.y = in_data.rot.y + x_shift;
            data_next.rot.z = in_data.rot.z - ATAN_STEP;
        end
        else
        begin
            data_next.rot.x = in_data.rot.x + y_shift;
            data_next.rot.y = in_data.rot.y - x_shift;
            data_next.rot.z = in_data.rot.z + ATAN_STEP;
        end
    end

    assign valid_next = in_valid;

    // Advance the request marker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Hand the data to the next cell
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

### hdl/vtu_axis_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module vtu_axis_lane (
    input  wire logic                              clk,
    input  wire vtu_pkg::lane_op_t                 lane_op,
    output logic signed [vtu_pkg::COORD_WIDTH-1:0] value,
    output logic                                   clipped
);

    localparam int W      = vtu_pkg::COORD_WIDTH;
    localparam int PROD_W = vtu_pkg::OPA_WIDTH + W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int RND_W  = SUM_W + 1;

    localparam logic signed [RND_W-1:0] LIMIT_MAX = {{(RND_W-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [RND_W-1:0] LIMIT_MIN = {{(RND_W-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [RND_W-1:0] HALF_ROT   = RND_W'(1) << (vtu_pkg::ROT_FRAC - 1);
    localparam logic signed [RND_W-1:0] HALF_SCALE = RND_W'(1) << (vtu_pkg::SCALE_FRAC - 1);

    // Stage 1: products
    vtu_pkg::lane_kind_t        kind1_reg;
    logic signed [PROD_W-1:0]   p1_reg;
    logic signed [PROD_W-1:0]   p1_next;
    logic signed [PROD_W-1:0]   p2_reg;
    logic signed [PROD_W-1:0]   p2_next;
    logic signed [W-1:0]        b1_reg;
    logic signed [W-1:0]        b2_reg;

    // Stage 2: combined sum
    vtu_pkg::lane_kind_t        kind2_reg;
    logic signed [SUM_W-1:0]    pre_reg;
    logic signed [SUM_W-1:0]    pre_next;

    // Stage 3: rounded and clipped value
    logic signed [RND_W-1:0]    rnd_sum;
    logic signed [RND_W-1:0]    shifted;
    logic signed [W-1:0]        value_reg;
    logic signed [W-1:0]        value_next;
    logic                       clipped_reg;
    logic                       clipped_next;

    // Form both products
    assign p1_next = lane_op.a1 * lane_op.b1;
    assign p2_next = lane_op.a2 * lane_op.b2;

    always_ff @(posedge clk)
    begin
        kind1_reg <= lane_op.kind;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        b1_reg    <= lane_op.b1;
        b2_reg    <= lane_op.b2;
    end

    // Combine products, or add the offset, or hold the coordinate
    always_comb
    begin
        unique case (kind1_reg)
            vtu_pkg::LANE_PASS:   pre_next = SUM_W'(b1_reg);
            vtu_pkg::LANE_ADD:    pre_next = SUM_W'(b1_reg) + SUM_W'(b2_reg);
            vtu_pkg::LANE_ROTATE: pre_next = SUM_W'(p1_reg) + SUM_W'(p2_reg);
            vtu_pkg::LANE_SCALE:  pre_next = SUM_W'(p1_reg) + SUM_W'(p2_reg);
            default:              pre_next = SUM_W'(b1_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        kind2_reg <= kind1_reg;
        pre_reg   <= pre_next;
    end

    // Round half up and drop fraction bits for rotate and scale, clip to coordinate range
    always_comb
    begin
        unique case (kind2_reg)
            vtu_pkg::LANE_ROTATE:
            begin
                rnd_sum = RND_W'(pre_reg) + HALF_ROT;
                shifted = rnd_sum >>> vtu_pkg::ROT_FRAC;
            end
            vtu_pkg::LANE_SCALE:
            begin
                rnd_sum = RND_W'(pre_reg) + HALF_SCALE;
                shifted = rnd_sum >>> vtu_pkg::SCALE_FRAC;
            end
            default:
            begin
                rnd_sum = RND_W'(pre_reg);
                shifted = rnd_sum;
            end
        endcase

        if (shifted > LIMIT_MAX)
        begin
            value_next   = LIMIT_MAX[W-1:0];
            clipped_next = 1'b1;
        end
        else if (shifted < LIMIT_MIN)
        begin
            value_next   = LIMIT_MIN[W-1:0];
            clipped_next = 1'b1;
        end
        else
        begin
            value_next   = shifted[W-1:0];
            clipped_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        clipped_reg <= clipped_next;
    end

    assign value   = value_reg;
    assign clipped = clipped_reg;

endmodule

`default_nettype wire

### hdl/vtu_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "vertex_transform_unit_macros.svh"

module vtu_checker #(
    parameter int CORDIC_STAGES = vtu_pkg::CORDIC_STAGES_DEFAULT
) (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire vtu_pkg::request_t request,
    input wire logic              done,
    input wire vtu_pkg::result_t  result
);

    localparam int LAT = CORDIC_STAGES + vtu_pkg::LANE_LATENCY;

    // Every request yields a result after the fixed latency
    `VTU_ASSERT_AFTER(a_fixed_latency, clk, rst_n, start && !busy, LAT, done)

    // No result without a request that latency ago
    `VTU_ASSERT_IMPLIES(a_no_spurious, clk, rst_n, done, $past(start && !busy, LAT))

    // Unused operation codes return the vertex unchanged and unclipped
    `VTU_ASSERT_IMPLIES(a_unused_pass, clk, rst_n,
        done && ($past(request.mode, LAT) > vtu_pkg::MODE_SCALE),
        (result.result_x == $past(request.vertex_x, LAT))
            && (result.result_y == $past(request.vertex_y, LAT))
            && (result.result_z == $past(request.vertex_z, LAT)) && !result.saturated)

    // Rotation about Z leaves the Z coordinate untouched
    `VTU_ASSERT_IMPLIES(a_rotz_axis, clk, rst_n,
        done && ($past(request.mode, LAT) == vtu_pkg::MODE_ROTATE_Z),
        result.result_z == $past(request.vertex_z, LAT))

endmodule

bind vertex_transform_unit vtu_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_vtu_checker (.*);

`default_nettype wire
